[sv/bpc_pkg.sv]
// Shared types, register indexes and constants for the blit pixel compositor.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

   localparam int CHAN_W   = 8;
   localparam int ALPHA_W  = 9;
   localparam int KEY_W    = 24;
   localparam int MODE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = 16;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [MODE_W-1:0]  MODE_RESET  = 3'd0;
   localparam logic [KEY_W-1:0]   KEY_RESET   = 24'hff00ff;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
   localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_KEY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_Q8   = 2'd2;

   // blend mode codes
   localparam logic [MODE_W-1:0] MODE_COPY      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_KEY       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_AVG       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_KEY_AVG   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ALPHA     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_KEY_ALPHA = 3'd5;
   localparam logic [MODE_W-1:0] MODE_ADD       = 3'd6;

   typedef enum logic [2:0] {
      OP_COPY,
      OP_HOLD,
      OP_AVG,
      OP_ALPHA,
      OP_ADD
   } bpc_op_type;

   typedef struct packed {
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] dst_blue;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_red;
   } bpc_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic              write_enable;
   } bpc_rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]  blend_mode;
      logic [KEY_W-1:0]   color_key;
      logic [ALPHA_W-1:0] alpha_sat;
   } bpc_cfg_type;

   // per-pixel control handed to each channel lane
   typedef struct packed {
      bpc_op_type         op;
      logic [ALPHA_W-1:0] alpha;
      logic [ALPHA_W-1:0] alpha_inv;
   } bpc_ctl_type;

endpackage
`default_nettype wire

[sv/bpc_csr.sv]
// Configuration registers with alpha saturation.
`timescale 1ns / 1ps
`default_nettype none
module bpc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::KEY_W-1:0]      csr_wdata,
   output bpc_pkg::bpc_cfg_type                cfg
);
   import bpc_pkg::*;

   logic [MODE_W-1:0]  mode_ff,  mode_in;
   logic [KEY_W-1:0]   key_ff,   key_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   always_comb begin
      mode_in  = mode_ff;
      key_in   = key_ff;
      alpha_in = alpha_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BLEND_MODE: mode_in  = csr_wdata[MODE_W-1:0];
            REG_COLOR_KEY:  key_in   = csr_wdata;
            REG_ALPHA_Q8:   alpha_in = csr_wdata[ALPHA_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         key_ff   <= KEY_RESET;
         alpha_ff <= ALPHA_RESET;
      end else begin
         mode_ff  <= mode_in;
         key_ff   <= key_in;
         alpha_ff <= alpha_in;
      end
   end

   assign cfg.blend_mode = mode_ff;
   assign cfg.color_key  = key_ff;
   assign cfg.alpha_sat  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

endmodule
`default_nettype wire

[sv/bpc_chan.sv]
// Three-stage arithmetic lane for one color channel.
`timescale 1ns / 1ps
`default_nettype none
module bpc_chan (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [bpc_pkg::CHAN_W-1:0]  src,
   input  wire logic [bpc_pkg::CHAN_W-1:0]  dst,
   input  wire bpc_pkg::bpc_ctl_type        ctl,
   output logic [bpc_pkg::CHAN_W-1:0]       result
);
   import bpc_pkg::*;

   // stage 1: operands
   logic [CHAN_W-1:0] s1_src_ff, s1_dst_ff;
   bpc_ctl_type       s1_ctl_ff;
   // stage 2: products and plain sum
   logic [PROD_W-1:0] s2_pd_ff, s2_pd_in;
   logic [PROD_W-1:0] s2_ps_ff, s2_ps_in;
   logic [CHAN_W:0]   s2_sum_ff, s2_sum_in;
   logic [CHAN_W-1:0] s2_src_ff, s2_dst_ff;
   bpc_op_type        s2_op_ff;
   // stage 3: result
   logic [CHAN_W-1:0] s3_res_ff, s3_res_in;
   logic [PROD_W-1:0] blend_sum;

   assign s2_pd_in  = PROD_W'(s1_dst_ff) * PROD_W'(s1_ctl_ff.alpha_inv);
   assign s2_ps_in  = PROD_W'(s1_src_ff) * PROD_W'(s1_ctl_ff.alpha);
   assign s2_sum_in = {1'b0, s1_dst_ff} + {1'b0, s1_src_ff};

   // weights add to 256, so the sum never exceeds 255*256
   assign blend_sum = s2_pd_ff + s2_ps_ff;

   always_comb begin
      unique case (s2_op_ff)
         OP_HOLD:  s3_res_in = s2_dst_ff;
         OP_AVG:   s3_res_in = s2_sum_ff[CHAN_W:1];
         OP_ALPHA: s3_res_in = blend_sum[PROD_W-1:CHAN_W];
         OP_ADD:   s3_res_in = s2_sum_ff[CHAN_W] ? CHAN_MAX : s2_sum_ff[CHAN_W-1:0];
         default:  s3_res_in = s2_src_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_src_ff <= src;
         s1_dst_ff <= dst;
         s1_ctl_ff <= ctl;
         s2_pd_ff  <= s2_pd_in;
         s2_ps_ff  <= s2_ps_in;
         s2_sum_ff <= s2_sum_in;
         s2_src_ff <= s1_src_ff;
         s2_dst_ff <= s1_dst_ff;
         s2_op_ff  <= s1_ctl_ff.op;
         s3_res_ff <= s3_res_in;
      end
   end

   assign result = s3_res_ff;

endmodule
`default_nettype wire

[sv/blit_pixel_compositor.sv]
// Top level: per-pixel blit combiner with copy, color key, average, alpha and additive modes.
// A request passes the operand, product and result stages in order before rsp_valid rises.
// Throughput: one pixel per cycle when not stalled; depth set by the 8x9 alpha multiply stage.
// A stall on rsp_ready holds all three stages together; req_ready drops with it.
// Reset (synchronous) clears the stage valid bits and loads mode 0, key 0xFF00FF, alpha 128.
`timescale 1ns / 1ps
`default_nettype none
module blit_pixel_compositor (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire bpc_pkg::bpc_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bpc_pkg::bpc_rsp_type                rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::KEY_W-1:0]      csr_wdata
);
   import bpc_pkg::*;

   bpc_cfg_type cfg;
   bpc_ctl_type ctl;
   logic        en;
   logic        key_hit;
   logic        keyed;
   logic        alpha_mode;
   logic [KEY_W-1:0] packed_src;
   logic [2:0]  valid_ff;
   logic [2:0]  we_ff;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the whole pipe unless a finished result is stuck
   assign en        = !valid_ff[2] || rsp_ready;
   assign req_ready = en;

   assign packed_src = {req_data.src_red, req_data.src_green, req_data.src_blue};
   assign keyed      = (cfg.blend_mode == MODE_KEY) || (cfg.blend_mode == MODE_KEY_AVG) ||
                       (cfg.blend_mode == MODE_KEY_ALPHA);
   assign alpha_mode = (cfg.blend_mode == MODE_ALPHA) || (cfg.blend_mode == MODE_KEY_ALPHA);
   assign key_hit    = keyed && (packed_src == cfg.color_key);

   always_comb begin
      ctl.alpha     = cfg.alpha_sat;
      ctl.alpha_inv = ALPHA_ONE - cfg.alpha_sat;
      priority if (key_hit) begin
         ctl.op = OP_HOLD;
      end else if (alpha_mode && cfg.alpha_sat == '0) begin
         ctl.op = OP_HOLD;
      end else if (alpha_mode) begin
         ctl.op = OP_ALPHA;
      end else if (cfg.blend_mode == MODE_AVG || cfg.blend_mode == MODE_KEY_AVG) begin
         ctl.op = OP_AVG;
      end else if (cfg.blend_mode == MODE_ADD) begin
         ctl.op = OP_ADD;
      end else begin
         ctl.op = OP_COPY;
      end
   end

   bpc_chan u_blue (
      .clock  (clock),
      .en     (en),
      .src    (req_data.src_blue),
      .dst    (req_data.dst_blue),
      .ctl    (ctl),
      .result (rsp_data.out_blue)
   );

   bpc_chan u_green (
      .clock  (clock),
      .en     (en),
      .src    (req_data.src_green),
      .dst    (req_data.dst_green),
      .ctl    (ctl),
      .result (rsp_data.out_green)
   );

   bpc_chan u_red (
      .clock  (clock),
      .en     (en),
      .src    (req_data.src_red),
      .dst    (req_data.dst_red),
      .ctl    (ctl),
      .result (rsp_data.out_red)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         we_ff <= {we_ff[1:0], ctl.op != OP_HOLD};
      end
   end

   assign rsp_valid             = valid_ff[2];
   assign rsp_data.write_enable = we_ff[2];

endmodule
`default_nettype wire

[sv/bpc_checker.sv]
// Port-level checks for the blit pixel compositor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire bpc_pkg::bpc_req_type           req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire bpc_pkg::bpc_rsp_type           rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::KEY_W-1:0]      csr_wdata
);
   import bpc_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request blocked while output can drain");

   // an accepted request reaches the output when rsp_ready does not stall the pipe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("request did not arrive at output in time");

endmodule

bind blit_pixel_compositor bpc_checker u_bpc_checker (.*);
`default_nettype wire

[tb/tb_blit_pixel_compositor.sv]
// Testbench for the blit pixel compositor: directed and random pixels checked against a model.
`timescale 1ns / 1ps
module tb_blit_pixel_compositor;
   import bpc_pkg::*;

   localparam logic [MODE_W-1:0]    MODE_SPARE = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE  = 2'd3;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 36;
   localparam int CYCLE_LIMIT = 100000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   bpc_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   bpc_rsp_type          rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KEY_W-1:0]     csr_wdata = '0;

   // register image kept alongside the block
   logic [MODE_W-1:0]  cfg_mode  = MODE_RESET;
   logic [KEY_W-1:0]   cfg_key   = KEY_RESET;
   logic [ALPHA_W-1:0] cfg_alpha = ALPHA_RESET;

   bpc_rsp_type pending_pixels[$];
   int          error_count = 0;
   int          cycle_count = 0;
   logic        calm = 1'b0;

   blit_pixel_compositor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 36);
   end

   function automatic logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] d,
                                                       logic [CHAN_W-1:0] s,
                                                       logic [ALPHA_W-1:0] a);
      logic [CHAN_W:0] sum;
      logic [31:0]     mix;
      sum = {1'b0, d} + {1'b0, s};
      mix = 32'(d) * (32'(ALPHA_ONE) - 32'(a)) + 32'(s) * 32'(a);
      case (cfg_mode)
         MODE_AVG, MODE_KEY_AVG:     return sum[CHAN_W:1];
         MODE_ALPHA, MODE_KEY_ALPHA: return mix[15:8];
         MODE_ADD:                   return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
         default:                    return s;
      endcase
   endfunction

   function automatic bpc_rsp_type compose_pixel(bpc_req_type px);
      bpc_rsp_type        r;
      logic [KEY_W-1:0]   src_rgb;
      logic [ALPHA_W-1:0] a;
      logic               keyed;
      a = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
      src_rgb = {px.src_red, px.src_green, px.src_blue};
      keyed = (cfg_mode == MODE_KEY) || (cfg_mode == MODE_KEY_AVG) ||
              (cfg_mode == MODE_KEY_ALPHA);
      r.out_blue = px.dst_blue;
      r.out_green = px.dst_green;
      r.out_red = px.dst_red;
      r.write_enable = 1'b0;
      // transparent source or zero weight: keep the destination, no write
      if (!(keyed && src_rgb == cfg_key) &&
          !((cfg_mode == MODE_ALPHA || cfg_mode == MODE_KEY_ALPHA) && a == '0)) begin
         r.out_blue = blend_channel(px.dst_blue, px.src_blue, a);
         r.out_green = blend_channel(px.dst_green, px.src_green, a);
         r.out_red = blend_channel(px.dst_red, px.src_red, a);
         r.write_enable = 1'b1;
      end
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   // record each accepted request, then check each accepted result
   always @(posedge clock) begin
      bpc_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_pixels.push_back(compose_pixel(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               report_error($sformatf("response with no request pending: %h", rsp_data));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_data.out_blue !== want.out_blue)
                  report_error($sformatf("out_blue expected %h got %h",
                                         want.out_blue, rsp_data.out_blue));
               if (rsp_data.out_green !== want.out_green)
                  report_error($sformatf("out_green expected %h got %h",
                                         want.out_green, rsp_data.out_green));
               if (rsp_data.out_red !== want.out_red)
                  report_error($sformatf("out_red expected %h got %h",
                                         want.out_red, rsp_data.out_red));
               if (rsp_data.write_enable !== want.write_enable)
                  report_error($sformatf("write_enable expected %b got %b",
                                         want.write_enable, rsp_data.write_enable));
            end
         end
      end
   end

   function automatic bpc_req_type make_pixel(logic [KEY_W-1:0] src_rgb,
                                              logic [KEY_W-1:0] dst_rgb);
      bpc_req_type px;
      px.src_red = src_rgb[23:16];
      px.src_green = src_rgb[15:8];
      px.src_blue = src_rgb[7:0];
      px.dst_red = dst_rgb[23:16];
      px.dst_green = dst_rgb[15:8];
      px.dst_blue = dst_rgb[7:0];
      return px;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_channel();
      case ($urandom_range(9))
         0:       return '0;
         1:       return CHAN_MAX;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input bpc_req_type px);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid and let every pending request come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_BLEND_MODE: cfg_mode = data[MODE_W-1:0];
         REG_COLOR_KEY:  cfg_key = data;
         REG_ALPHA_Q8:   cfg_alpha = data[ALPHA_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits beyond each register's width carry junk
   task automatic configure(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic [ALPHA_W-1:0] alpha);
      logic [31:0] junk;
      junk = $urandom;
      wait_idle();
      write_reg(REG_BLEND_MODE, {junk[20:0], mode});
      write_reg(REG_COLOR_KEY, key);
      write_reg(REG_ALPHA_Q8, {junk[31:17], alpha});
   endtask

   task automatic test_reset_values();
      send_pixel(make_pixel(24'h123456, 24'hfedcba));
      wait_idle();
      write_reg(REG_BLEND_MODE, {21'd0, MODE_KEY});
      send_pixel(make_pixel(24'hff00ff, 24'h0a0b0c));
      wait_idle();
      write_reg(REG_BLEND_MODE, {21'd0, MODE_ALPHA});
      send_pixel(make_pixel(24'hffffff, 24'h000000));
   endtask

   task automatic test_copy();
      configure(MODE_COPY, 24'h000000, 9'd0);
      send_pixel(make_pixel(24'h000000, 24'hffffff));
      send_pixel(make_pixel(24'hffffff, 24'h000000));
      configure(MODE_SPARE, 24'h5a5a5a, 9'd0);
      send_pixel(make_pixel(24'h5a5a5a, 24'h13579b));
   endtask

   task automatic test_color_key();
      configure(MODE_KEY, 24'h123456, 9'd64);
      send_pixel(make_pixel(24'h123456, 24'h998877));
      send_pixel(make_pixel(24'h123457, 24'h998877));
      configure(MODE_KEY_AVG, 24'h000000, 9'd64);
      send_pixel(make_pixel(24'h000000, 24'hffffff));
      configure(MODE_KEY_ALPHA, 24'hffffff, 9'd200);
      send_pixel(make_pixel(24'hffffff, 24'h102030));
      // key has no effect outside the keyed modes
      configure(MODE_ADD, 24'h123456, 9'd64);
      send_pixel(make_pixel(24'h123456, 24'h010101));
   endtask

   task automatic test_average();
      configure(MODE_AVG, 24'hff00ff, 9'd0);
      send_pixel(make_pixel(24'hffffff, 24'hffffff));
      send_pixel(make_pixel(24'hffffff, 24'h000001));
   endtask

   task automatic test_alpha();
      configure(MODE_ALPHA, 24'hff00ff, 9'd0);
      send_pixel(make_pixel(24'hffffff, 24'h204060));
      configure(MODE_ALPHA, 24'hff00ff, 9'd1);
      send_pixel(make_pixel(24'hffffff, 24'h000000));
      configure(MODE_ALPHA, 24'hff00ff, 9'd255);
      send_pixel(make_pixel(24'h00ff80, 24'hff0080));
      configure(MODE_ALPHA, 24'hff00ff, ALPHA_ONE);
      send_pixel(make_pixel(24'hc0ffee, 24'hffffff));
      // weights past full source saturate
      configure(MODE_ALPHA, 24'hff00ff, 9'd511);
      send_pixel(make_pixel(24'h0f1e2d, 24'hffffff));
      configure(MODE_KEY_ALPHA, 24'hff00ff, 9'd0);
      send_pixel(make_pixel(24'h123456, 24'h654321));
   endtask

   task automatic test_additive();
      configure(MODE_ADD, 24'hff00ff, 9'd128);
      send_pixel(make_pixel(24'hffffff, 24'h01ff80));
      send_pixel(make_pixel(24'h102030, 24'h203040));
   endtask

   task automatic test_random_phases();
      logic [MODE_W-1:0]  mode;
      logic [KEY_W-1:0]   key;
      logic [ALPHA_W-1:0] alpha;
      logic [KEY_W-1:0]   src_rgb;
      logic [KEY_W-1:0]   dst_rgb;
      for (int phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 8) ? MODE_W'(phase) :
                MODE_W'($urandom_range(MODE_ALPHA, MODE_KEY_ALPHA));
         case ($urandom_range(3))
            0:       key = '0;
            1:       key = '1;
            default: key = KEY_W'($urandom);
         endcase
         case ($urandom_range(7))
            0:       alpha = '0;
            1:       alpha = ALPHA_ONE;
            2:       alpha = ALPHA_W'($urandom_range(257, 511));
            3:       alpha = 9'd1;
            4:       alpha = 9'd255;
            default: alpha = ALPHA_W'($urandom_range(511));
         endcase
         configure(mode, key, alpha);
         if ($urandom_range(1))
            write_reg(REG_SPARE, KEY_W'($urandom));
         // one phase runs both sides flat out
         calm = (phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(7))
               0, 1:    src_rgb = cfg_key;
               2:       src_rgb = cfg_key ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
               default: src_rgb = {rand_channel(), rand_channel(), rand_channel()};
            endcase
            dst_rgb = {rand_channel(), rand_channel(), rand_channel()};
            send_pixel(make_pixel(src_rgb, dst_rgb));
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_copy();
      test_color_key();
      test_average();
      test_alpha();
      test_additive();
      test_random_phases();
      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
